/* rtl/sound_voice_allocator_macros.svh */
// Assertion macros shared by the checkers of the sound voice allocator.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef SOUND_VOICE_ALLOCATOR_MACROS_SVH
`define SOUND_VOICE_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SNDVA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sound voice allocator check failed");

// Consequent must hold in the cycle after the antecedent.
`define SNDVA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sound voice allocator check failed");

`endif

/* rtl/sndva_pkg.sv */
// Shared types and constants of the sound voice allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sndva_pkg;

  localparam int unsigned VOICES_DEF = 8;

  localparam int unsigned DIST_W    = 34;
  localparam int unsigned ATT_SHIFT = 20;
  localparam int unsigned ATT_W     = DIST_W - ATT_SHIFT;

  localparam logic [6:0]  VOL_MAX           = 7'd127;
  localparam int unsigned LEVEL_DIV         = 255;
  localparam logic [7:0]  EFFECT_VOLUME_RST = 8'd128;

  localparam logic REG_EFFECT_VOLUME    = 1'b0;
  localparam logic REG_EFFECTS_DISABLED = 1'b1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DONE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_STARTED   = 3'd0,
    ST_TOO_FAR   = 3'd1,
    ST_NO_SAMPLE = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_NO_VOICE  = 3'd4,
    ST_SOUND_OFF = 3'd5,
    ST_EVENT     = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0]  effect;
    logic [15:0] origin;
    logic [7:0]  prio;
  } voice_entry_t;

endpackage

`default_nettype wire

/* rtl/sndva_dist.sv */
// Three-stage octagonal distance pipeline producing the attenuation.
// Depends on sndva_pkg for the distance and attenuation widths.
`timescale 1ns / 1ps
`default_nettype none

module sndva_dist (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic signed [31:0]              source_x_i,
  input  logic signed [31:0]              source_y_i,
  input  logic signed [31:0]              listener_x_i,
  input  logic signed [31:0]              listener_y_i,
  output logic                            valid_o,
  output logic [sndva_pkg::ATT_W-1:0]     att_o
);
  import sndva_pkg::*;

  function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? (~d + 33'd1) : d;
  endfunction

  logic [2:0]        vld_q;
  logic [32:0]       dx_q, dy_q;
  logic [DIST_W-1:0] sum_q;
  logic [32:0]       half_q;
  logic [DIST_W-1:0] oct_dist;

  assign oct_dist = sum_q - DIST_W'(half_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= abs_diff(source_x_i, listener_x_i);
    dy_q   <= abs_diff(source_y_i, listener_y_i);
    sum_q  <= DIST_W'(dx_q) + DIST_W'(dy_q);
    half_q <= ((dx_q < dy_q) ? dx_q : dy_q) >> 1;
    att_o  <= oct_dist[DIST_W-1:ATT_SHIFT];
  end

  assign valid_o = vld_q[2];

endmodule

`default_nettype wire

/* rtl/sound_voice_allocator.sv */
// Sound voice allocator: distance, voice scan and stealing over a voice memory.
// Depends on sndva_pkg and instantiates sndva_dist.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// cmd selects a start request, a finished voice, a mixing tick or no operation.
// Every item produces exactly one result, shown for one cycle with done_o high;
// the receiver cannot stall, so results are never held back.
// Finished-voice, tick, no-operation items and start requests while effects are
// disabled answer in the cycle after acceptance and keep busy low.
// A start request first passes through the distance pipeline, and a too-far or
// missing-sample answer follows its result. Otherwise the voice memory is scanned
// one entry per cycle behind a registered read and the chosen entry is committed:
// a started voice answers after the commit, a duplicate or no-voice answer from
// the scan itself.
// busy stays high until the result appears; items are handled one at a time.
// The APB port holds effect_volume at 0x0 and effects_disabled at 0x4; pready is
// always high. Reset sets effect_volume to 128 and marks every voice unassigned,
// idle and not at its start; memory entries of unassigned voices read as zero.
`timescale 1ns / 1ps
`default_nettype none

module sound_voice_allocator #(
  parameter int unsigned VOICES = sndva_pkg::VOICES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [15:0]        origin_id_i,
  input  logic               from_listener_i,
  input  logic signed [31:0] source_x_i,
  input  logic signed [31:0] source_y_i,
  input  logic signed [31:0] listener_x_i,
  input  logic signed [31:0] listener_y_i,
  input  logic [7:0]         effect_id_i,
  input  logic [7:0]         effect_priority_i,
  input  logic               singular_i,
  input  logic               has_sample_i,
  input  logic [2:0]         voice_index_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [2:0]         voice_o,
  output logic               cut_playing_o,
  output logic [14:0]        voice_level_o,
  output logic [6:0]         play_volume_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sndva_pkg::*;

  localparam int unsigned IdxW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CntW = $clog2(VOICES + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIST, S_SCAN, S_COMMIT} state_e;

  state_e               state_q;
  logic [7:0]           ev_q;
  logic                 dis_q;
  logic                 level_on_q;
  logic [VOICES-1:0]    asg_q, play_q, at_start_q;

  logic [15:0]          org_q;
  logic [7:0]           eff_q, pri_q;
  logic                 sing_q, sample_q, near_q;
  logic [6:0]           vol_q;
  logic [14:0]          level_q;

  logic [CntW-1:0]      scan_cnt_q;
  logic                 chk_vld_q;
  logic [IdxW-1:0]      chk_idx_q;
  logic                 steal_found_q, steal_cut_q;
  logic [IdxW-1:0]      steal_idx_q;
  logic [IdxW-1:0]      sel_idx_q;
  logic                 sel_cut_q;

  logic                 done_q, cut_q;
  status_e              status_q;
  logic [2:0]           voice_q;
  logic [14:0]          lvl_out_q;
  logic [6:0]           pvol_q;

  voice_entry_t         mem_q [VOICES];
  voice_entry_t         rd_q;

  logic                 accept, cfg_wr, dist_vld;
  logic [ATT_W-1:0]     att;
  voice_entry_t         entry;
  logic                 same_eff, hit_dup, hit_take, steal_hit, last_chk;
  logic [IdxW-1:0]      raddr, fin_idx;
  logic                 fin_ok;
  logic [15:0]          pv_sum;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign raddr   = scan_cnt_q[IdxW-1:0];
  assign fin_idx = IdxW'(voice_index_i);
  assign fin_ok  = (32'(voice_index_i) < VOICES);

  assign entry     = asg_q[chk_idx_q] ? rd_q : '0;
  assign same_eff  = asg_q[chk_idx_q] && (entry.effect == eff_q);
  assign hit_dup   = same_eff && at_start_q[chk_idx_q];
  assign hit_take  = (same_eff && sing_q) || (entry.origin == org_q) || !play_q[chk_idx_q];
  assign steal_hit = (entry.prio >= pri_q);
  assign last_chk  = (chk_idx_q == IdxW'(VOICES - 1));

  // Exact division by 255 for levels below 32640.
  assign pv_sum = 16'(level_q) + 16'd1 + 16'(level_q[14:8]);

  sndva_dist u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept && (cmd_e'(cmd_i) == CMD_START) && !dis_q),
    .source_x_i   (source_x_i),
    .source_y_i   (source_y_i),
    .listener_x_i (listener_x_i),
    .listener_y_i (listener_y_i),
    .valid_o      (dist_vld),
    .att_o        (att)
  );

  always_comb begin
    unique case (paddr[2])
      REG_EFFECT_VOLUME:    prdata = 32'(ev_q);
      REG_EFFECTS_DISABLED: prdata = 32'(dis_q);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_COMMIT) begin
      mem_q[sel_idx_q] <= '{effect: eff_q, origin: org_q, prio: pri_q};
    end
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ev_q          <= EFFECT_VOLUME_RST;
      dis_q         <= 1'b0;
      level_on_q    <= 1'b1;
      asg_q         <= '0;
      play_q        <= '0;
      at_start_q    <= '0;
      scan_cnt_q    <= '0;
      chk_vld_q     <= 1'b0;
      chk_idx_q     <= '0;
      steal_found_q <= 1'b0;
      steal_cut_q   <= 1'b0;
      steal_idx_q   <= '0;
      sel_idx_q     <= '0;
      sel_cut_q     <= 1'b0;
      done_q        <= 1'b0;
      status_q      <= ST_EVENT;
      voice_q       <= '0;
      cut_q         <= 1'b0;
      lvl_out_q     <= '0;
      pvol_q        <= '0;
    end else begin
      done_q    <= 1'b0;
      voice_q   <= '0;
      cut_q     <= 1'b0;
      lvl_out_q <= '0;
      pvol_q    <= '0;

      if (cfg_wr) begin
        unique case (paddr[2])
          REG_EFFECT_VOLUME:    ev_q  <= pwdata[7:0];
          REG_EFFECTS_DISABLED: dis_q <= pwdata[0];
          default:              ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            org_q    <= origin_id_i;
            eff_q    <= effect_id_i;
            pri_q    <= effect_priority_i;
            sing_q   <= singular_i;
            sample_q <= has_sample_i;
            near_q   <= (origin_id_i == '0) || from_listener_i;
            unique case (cmd_e'(cmd_i))
              CMD_START: begin
                if (dis_q) begin
                  done_q   <= 1'b1;
                  status_q <= ST_SOUND_OFF;
                end else begin
                  state_q <= S_DIST;
                end
              end
              CMD_DONE: begin
                if (fin_ok) begin
                  play_q[fin_idx] <= 1'b0;
                end
                done_q   <= 1'b1;
                status_q <= ST_EVENT;
              end
              CMD_TICK: begin
                at_start_q <= '0;
                if (ev_q == '0) begin
                  if (level_on_q) begin
                    level_on_q <= 1'b0;
                    asg_q      <= '0;
                    play_q     <= '0;
                  end
                end else begin
                  level_on_q <= 1'b1;
                end
                done_q   <= 1'b1;
                status_q <= ST_EVENT;
              end
              CMD_NOP: begin
                done_q   <= 1'b1;
                status_q <= ST_EVENT;
              end
              default: ;
            endcase
          end
        end

        S_DIST: begin
          if (dist_vld) begin
            priority if (!near_q && (att > ATT_W'(VOL_MAX))) begin
              done_q   <= 1'b1;
              status_q <= ST_TOO_FAR;
              state_q  <= S_IDLE;
            end else if (!sample_q) begin
              done_q   <= 1'b1;
              status_q <= ST_NO_SAMPLE;
              state_q  <= S_IDLE;
            end else begin
              vol_q         <= near_q ? VOL_MAX : (VOL_MAX - att[6:0]);
              scan_cnt_q    <= '0;
              chk_vld_q     <= 1'b0;
              steal_found_q <= 1'b0;
              state_q       <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          level_q <= 15'(vol_q) * 15'(ev_q);
          if (scan_cnt_q < CntW'(VOICES)) begin
            scan_cnt_q <= scan_cnt_q + CntW'(1);
            chk_vld_q  <= 1'b1;
            chk_idx_q  <= scan_cnt_q[IdxW-1:0];
          end else begin
            chk_vld_q <= 1'b0;
          end
          if (chk_vld_q) begin
            priority if (hit_dup) begin
              done_q   <= 1'b1;
              status_q <= ST_DUPLICATE;
              state_q  <= S_IDLE;
            end else if (hit_take) begin
              sel_idx_q <= chk_idx_q;
              sel_cut_q <= play_q[chk_idx_q];
              state_q   <= S_COMMIT;
            end else begin
              if (!steal_found_q && steal_hit) begin
                steal_found_q <= 1'b1;
                steal_idx_q   <= chk_idx_q;
                steal_cut_q   <= play_q[chk_idx_q];
              end
              if (last_chk) begin
                priority if (steal_found_q) begin
                  sel_idx_q <= steal_idx_q;
                  sel_cut_q <= steal_cut_q;
                  state_q   <= S_COMMIT;
                end else if (steal_hit) begin
                  sel_idx_q <= chk_idx_q;
                  sel_cut_q <= play_q[chk_idx_q];
                  state_q   <= S_COMMIT;
                end else begin
                  done_q   <= 1'b1;
                  status_q <= ST_NO_VOICE;
                  state_q  <= S_IDLE;
                end
              end
            end
          end
        end

        S_COMMIT: begin
          asg_q[sel_idx_q]      <= 1'b1;
          play_q[sel_idx_q]     <= 1'b1;
          at_start_q[sel_idx_q] <= 1'b1;
          done_q    <= 1'b1;
          status_q  <= ST_STARTED;
          voice_q   <= 3'(sel_idx_q);
          cut_q     <= sel_cut_q;
          lvl_out_q <= level_q;
          pvol_q    <= pv_sum[14:8];
          state_q   <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign voice_o       = voice_q;
  assign cut_playing_o = cut_q;
  assign voice_level_o = lvl_out_q;
  assign play_volume_o = pvol_q;

endmodule

`default_nettype wire

/* rtl/sndva_checker.sv */
// Port-level checks of the sound voice allocator, bound to the top level.
// Depends on sndva_pkg and sound_voice_allocator_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sound_voice_allocator_macros.svh"

module sndva_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [2:0]  status_o,
  input wire logic [2:0]  voice_o,
  input wire logic        cut_playing_o,
  input wire logic [14:0] voice_level_o,
  input wire logic [6:0]  play_volume_o
);
  import sndva_pkg::*;

  `SNDVA_ASSERT_NXT(a_item_progress, start && !busy, busy || done_o)
  `SNDVA_ASSERT_IMP(a_done_frees, done_o, !busy)
  `SNDVA_ASSERT_IMP(a_busy_from_item, $rose(busy), $past(start))
  `SNDVA_ASSERT_IMP(a_reject_zero, done_o && (status_o != ST_STARTED), (voice_o == '0) && !cut_playing_o && (voice_level_o == '0) && (play_volume_o == '0))
  `SNDVA_ASSERT_IMP(a_play_volume, done_o && (status_o == ST_STARTED), (16'(play_volume_o) * 16'(LEVEL_DIV) <= 16'(voice_level_o)) && (16'(voice_level_o) < 16'(play_volume_o) * 16'(LEVEL_DIV) + 16'(LEVEL_DIV)))

endmodule

bind sound_voice_allocator sndva_checker u_sndva_checker (.*);

`default_nettype wire
